@@ src/m3i_pkg.sv @@
`timescale 1ns / 1ps
package m3i_pkg;

  // one divider lane per inverse element
  localparam int NLANE = 9;

  // cofactor k = m[a]*m[b] - m[c]*m[d], element index = row*3+col, transposed
  localparam int COF_IDX [NLANE][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // determinant expands down column 0: m00*cof0 + m10*cof1 + m20*cof2
  localparam int DET_ELEM [3] = '{0, 3, 6};

endpackage

@@ src/matrix3x3_inverse.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Ports                          Item
// in_      in   tvalid tready tdata[9E]        m00..m22
// out_     out  tvalid tready tdata[9E] tuser  r00..r22, singular, overflow
//
// Full pipeline: one item per cycle while the output is not stalled; each of
// the nine element lanes divides with one quotient bit per stage.
// Reset clears only the valid pipeline; data registers are not reset.
// A stalled output holds the whole pipeline; in_tready follows out_tready
// whenever the output register is full.
module matrix3x3_inverse #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, zero padded
  input  logic [((m3i_pkg::NLANE*ELEMENT_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 from bit 0 up, zero padded
  output logic [((m3i_pkg::NLANE*ELEMENT_WIDTH+7)/8)*8-1:0] out_tdata,
  // singular, overflow from bit 0 up
  output logic [1:0] out_tuser
);
  import m3i_pkg::*;

  localparam int E  = ELEMENT_WIDTH;
  localparam int CW = 2 * E + 1;
  localparam int DW = 3 * E + 3;
  localparam int BW = ((NLANE * E + 7) / 8) * 8;
  localparam int NS = E + 9;
  localparam int LL = E + 3;

  logic               en;
  logic [NS-1:0]      vld_r;
  logic [NLANE*CW-1:0] cof;
  logic [DW-1:0]      det;
  logic [NLANE*CW-1:0] cof5_r;
  logic [DW-1:0]      dmag_r;
  logic               dneg_r;
  logic [LL:0]        sing_r;
  logic [NLANE*E-1:0] res;
  logic [NLANE-1:0]   ovf;
  logic [NLANE*E-1:0] data_r;
  logic               sing_o_r;
  logic               ovf_o_r;

  // global advance: move unless the output holds an untaken item
  assign en        = !vld_r[NS-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_tvalid};
    end
  end

  m3i_front #(.ELEMENT_WIDTH(E)) u_front (
    .clk   (clk),
    .en    (en),
    .elems (in_tdata[NLANE*E-1:0]),
    .cof_o (cof),
    .det_o (det)
  );

  // determinant sign, magnitude and zero test
  always_ff @(posedge clk) begin
    if (en) begin
      dneg_r <= det[DW-1];
      dmag_r <= det[DW-1] ? -det : det;
      cof5_r <= cof;
      sing_r <= {sing_r[LL-1:0], det == '0};
    end
  end

  for (genvar k = 0; k < NLANE; k++) begin : g_lane
    m3i_lane #(.ELEMENT_WIDTH(E), .FRACTION_BITS(FRACTION_BITS)) u_lane (
      .clk  (clk),
      .en   (en),
      .cof  ($signed(cof5_r[k*CW +: CW])),
      .dmag (dmag_r),
      .dneg (dneg_r),
      .res  (res[k*E +: E]),
      .ovf  (ovf[k])
    );
  end

  // merge lanes: singular forces zeros and clears overflow, else overflow is any lane saturating
  always_ff @(posedge clk) begin
    if (en) begin
      data_r   <= sing_r[LL] ? '0 : res;
      sing_o_r <= sing_r[LL];
      ovf_o_r  <= !sing_r[LL] && (|ovf);
    end
  end

  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = BW'(data_r);
  assign out_tuser  = {ovf_o_r, sing_o_r};

endmodule

@@ src/m3i_front.sv @@
`timescale 1ns / 1ps
// Cofactors and determinant, four register stages.
module m3i_front #(
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic [m3i_pkg::NLANE*ELEMENT_WIDTH-1:0]  elems,
  output logic [m3i_pkg::NLANE*(2*ELEMENT_WIDTH+1)-1:0] cof_o,
  output logic [3*ELEMENT_WIDTH+2:0]               det_o
);
  import m3i_pkg::*;

  localparam int E  = ELEMENT_WIDTH;
  localparam int CW = 2 * E + 1;
  localparam int DW = 3 * E + 3;

  logic signed [2*E-1:0] pa_r [NLANE];
  logic signed [2*E-1:0] pb_r [NLANE];
  logic signed [E-1:0]   m1_r [3];
  logic signed [E-1:0]   m2_r [3];
  logic signed [CW-1:0]  cof2_r [NLANE];
  logic signed [CW-1:0]  cof3_r [NLANE];
  logic signed [CW-1:0]  cof4_r [NLANE];
  logic signed [2*E:0]   tlo_r [3];
  logic signed [2*E:0]   thi_r [3];
  logic signed [DW-1:0]  det_r;

  // stage 1: the two products of every cofactor
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NLANE; k++) begin
        pa_r[k] <= $signed(elems[COF_IDX[k][0]*E +: E]) *
                   $signed(elems[COF_IDX[k][1]*E +: E]);
        pb_r[k] <= $signed(elems[COF_IDX[k][2]*E +: E]) *
                   $signed(elems[COF_IDX[k][3]*E +: E]);
      end
      for (int j = 0; j < 3; j++) begin
        m1_r[j] <= $signed(elems[DET_ELEM[j]*E +: E]);
      end
    end
  end

  // stage 2: cofactor differences
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NLANE; k++) begin
        cof2_r[k] <= CW'(pa_r[k]) - CW'(pb_r[k]);
      end
      m2_r <= m1_r;
    end
  end

  // stage 3: determinant terms, cofactor split in low and high halves
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        tlo_r[j] <= m2_r[j] * $signed({1'b0, cof2_r[j][E-1:0]});
        thi_r[j] <= m2_r[j] * $signed(cof2_r[j][CW-1:E]);
      end
      cof3_r <= cof2_r;
    end
  end

  // stage 4: determinant sum
  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= (DW'(thi_r[0]) <<< E) + DW'(tlo_r[0]) +
               (DW'(thi_r[1]) <<< E) + DW'(tlo_r[1]) +
               (DW'(thi_r[2]) <<< E) + DW'(tlo_r[2]);
      cof4_r <= cof3_r;
    end
  end

  for (genvar k = 0; k < NLANE; k++) begin : g_out
    assign cof_o[k*CW +: CW] = cof4_r[k];
  end
  assign det_o = det_r;

endmodule

@@ src/m3i_lane.sv @@
`timescale 1ns / 1ps
// One inverse element: |cofactor| * 2^(2F) / |det|, one quotient bit a stage,
// then saturation.
module m3i_lane #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [2*ELEMENT_WIDTH:0] cof,
  input  logic [3*ELEMENT_WIDTH+2:0]      dmag,
  input  logic                            dneg,
  output logic [ELEMENT_WIDTH-1:0]        res,
  output logic                            ovf
);
  localparam int E  = ELEMENT_WIDTH;
  localparam int CW = 2 * E + 1;
  localparam int DW = 3 * E + 3;
  localparam int RW = DW + 1;
  localparam int NW = CW + 2 * FRACTION_BITS;
  localparam int XW = ((NW > DW + E) ? NW : DW + E) + 1;

  localparam logic [E-1:0] MAXPOS = {1'b0, {(E-1){1'b1}}};
  localparam logic [E-1:0] MINMAG = {1'b1, {(E-1){1'b0}}};

  logic [CW-1:0] nmag_r;
  logic [DW-1:0] dm_a_r;
  logic          qn_a_r;
  logic [NW-1:0] num;

  logic [RW-1:0] rem_r [E+1];
  logic [E-1:0]  q_r   [E+1];
  logic [E-1:0]  low_r [E+1];
  logic [DW-1:0] dm_r  [E+1];
  logic          qn_r  [E+1];
  logic          big_r [E+1];

  logic [E-1:0]  res_r;
  logic          ovf_r;

  // stage A: sign and magnitude of the numerator
  always_ff @(posedge clk) begin
    if (en) begin
      nmag_r <= cof[CW-1] ? CW'(-cof) : CW'(cof);
      qn_a_r <= cof[CW-1] ^ dneg;
      dm_a_r <= dmag;
    end
  end

  // stage B: quotient at or above 2^E saturates; else seed remainder
  assign num = {nmag_r, {(2*FRACTION_BITS){1'b0}}};
  always_ff @(posedge clk) begin
    if (en) begin
      big_r[0] <= XW'(num) >= (XW'(dm_a_r) << E);
      rem_r[0] <= RW'(XW'(num) >> E);
      low_r[0] <= num[E-1:0];
      q_r[0]   <= '0;
      dm_r[0]  <= dm_a_r;
      qn_r[0]  <= qn_a_r;
    end
  end

  // restoring division, one quotient bit a stage
  for (genvar i = 0; i < E; i++) begin : g_div
    logic [RW-1:0] t;
    logic          ge;
    assign t  = {rem_r[i][RW-2:0], low_r[i][E-1-i]};
    assign ge = t >= {1'b0, dm_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? t - {1'b0, dm_r[i]} : t;
        q_r[i+1]   <= {q_r[i][E-2:0], ge};
        low_r[i+1] <= low_r[i];
        dm_r[i+1]  <= dm_r[i];
        qn_r[i+1]  <= qn_r[i];
        big_r[i+1] <= big_r[i];
      end
    end
  end

  // saturate to the signed element range and apply sign
  always_ff @(posedge clk) begin
    if (en) begin
      if (big_r[E]) begin
        res_r <= qn_r[E] ? MINMAG : MAXPOS;
        ovf_r <= 1'b1;
      end else if (!qn_r[E] && q_r[E] > MAXPOS) begin
        res_r <= MAXPOS;
        ovf_r <= 1'b1;
      end else if (qn_r[E] && q_r[E] > MINMAG) begin
        res_r <= MINMAG;
        ovf_r <= 1'b1;
      end else begin
        res_r <= qn_r[E] ? -q_r[E] : q_r[E];
        ovf_r <= 1'b0;
      end
    end
  end

  assign res = res_r;
  assign ovf = ovf_r;

endmodule
